/* hdl/lprc_pkg.sv */
package lprc_pkg;

  localparam int MAX_ROUTES_DEF = 256;
  localparam int LINKS_DEF      = 8;

  localparam int ADDR_W   = 32;
  localparam int PLEN_W   = 6;
  localparam int LINK_W   = 3;
  localparam int CNT_VAL_W = 32;
  localparam logic [PLEN_W-1:0] PREFIX_MAX = 6'd32;

  localparam logic [1:0] OP_WRITE    = 2'd0;
  localparam logic [1:0] OP_CLASSIFY = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;

  localparam logic KIND_LINK    = 1'b0;
  localparam logic KIND_COUNTER = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PLEN_W-1:0] plen;
    logic [LINK_W-1:0] link;
  } route_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_CREAD = 5'b00100,
    S_CUPD  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

endpackage

/* hdl/longest_prefix_route_counter_unit.sv */
// Route write: written into the route table on acceptance, no result.
// Classify: scans route_count entries (capped at MAX_ROUTES), then updates the counter of the
//   chosen link; the route table has one read port and the scan compares one entry per cycle.
// Counter read: passes through S_CREAD, S_CUPD and S_OUT. One item at a time; in_stall is high meanwhile.
// Reset (rst, synchronous) clears route_count, all link counters and the sequencer; the route
//   table is not cleared and holds nothing meaningful until written.
module longest_prefix_route_counter_unit #(
  parameter int MAX_ROUTES = lprc_pkg::MAX_ROUTES_DEF,
  parameter int LINKS      = lprc_pkg::LINKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  entry_index,
  input  logic [31:0] route_address,
  input  logic [5:0]  prefix_length,
  input  logic [2:0]  route_link,
  input  logic [31:0] packet_address,
  input  logic [2:0]  counter_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [31:0] result_value
);
  import lprc_pkg::*;

  localparam int IDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int CNT_W = $clog2(MAX_ROUTES + 1);
  localparam int CI_W  = (LINKS > 1) ? $clog2(LINKS) : 1;

  state_t state;

  logic [8:0]       route_count;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] lim_next;
  logic [CNT_W-1:0] scan_idx;
  logic             cmp_valid;
  logic [ADDR_W-1:0] paddr;
  logic [LINK_W-1:0] cidx;
  logic             is_read;
  logic             found;
  logic [PLEN_W-1:0] best_len;
  logic [LINK_W-1:0] best_link;

  route_t            route_mem [MAX_ROUTES];
  route_t            route_rd;
  route_t            route_wr;
  logic              route_we;
  logic [IDX_W-1:0]  route_waddr;
  logic [31:0]       entry_ext;

  logic [CNT_VAL_W-1:0] cnt_mem [LINKS];
  logic [LINKS-1:0]     cnt_valid;
  logic [CNT_VAL_W-1:0] cnt_rd;
  logic                 cnt_vld_rd;
  logic [CI_W-1:0]      cnt_addr;
  logic [CI_W-1:0]      cnt_addr_q;
  logic                 cnt_in_range;
  logic                 cnt_in_range_q;
  logic [LINK_W-1:0]    cnt_sel;
  logic [31:0]          cnt_sel_ext;
  logic [CNT_VAL_W-1:0] cnt_cur;
  logic                 cnt_we;
  logic [CNT_VAL_W-1:0] cnt_wdata;

  logic              in_acc;
  logic              out_load;
  logic [ADDR_W-1:0] mask;
  logic              match;
  logic              better;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  // cap the active table length at the table depth
  always_comb begin
    if (32'(route_count) > 32'(MAX_ROUTES)) begin
      lim_next = CNT_W'(MAX_ROUTES);
    end else begin
      lim_next = CNT_W'(route_count);
    end
  end

  assign entry_ext   = 32'(entry_index);
  assign route_waddr = entry_ext[IDX_W-1:0];
  assign route_we    = in_acc && (opcode == OP_WRITE) && (entry_ext < 32'(MAX_ROUTES));
  assign route_wr.addr = route_address;
  assign route_wr.plen = (prefix_length > PREFIX_MAX) ? PREFIX_MAX : prefix_length;
  assign route_wr.link = route_link;

  always_ff @(posedge clk) begin
    if (route_we) begin
      route_mem[route_waddr] <= route_wr;
    end
    if (state == S_SCAN) begin
      route_rd <= route_mem[scan_idx[IDX_W-1:0]];
    end
  end

  // shared compare unit: one table entry per cycle
  assign mask   = ~({ADDR_W{1'b1}} >> route_rd.plen);
  assign match  = ((paddr ^ route_rd.addr) & mask) == '0;
  assign better = match && (!found || (route_rd.plen > best_len));

  assign cnt_sel      = is_read ? cidx : best_link;
  assign cnt_sel_ext  = 32'(cnt_sel);
  assign cnt_addr     = cnt_sel_ext[CI_W-1:0];
  assign cnt_in_range = cnt_sel_ext < 32'(LINKS);

  assign cnt_cur   = cnt_vld_rd ? cnt_rd : '0;
  assign cnt_we    = (state == S_CUPD) && !is_read && cnt_in_range_q && (cnt_cur != '1);
  assign cnt_wdata = cnt_cur + CNT_VAL_W'(1);

  always_ff @(posedge clk) begin
    if (state == S_CREAD) begin
      cnt_rd <= cnt_mem[cnt_addr];
    end
    if (cnt_we) begin
      cnt_mem[cnt_addr_q] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= '0;
    end else if (cnt_we) begin
      cnt_valid[cnt_addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CREAD) begin
      cnt_vld_rd     <= cnt_valid[cnt_addr];
      cnt_addr_q     <= cnt_addr;
      cnt_in_range_q <= cnt_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      paddr   <= packet_address;
      cidx    <= counter_index;
      is_read <= (opcode == OP_READ);
      lim     <= lim_next;
    end
    // load the output register only once it is free
    if (out_load) begin
      result_kind  <= is_read ? KIND_COUNTER : KIND_LINK;
      result_value <= is_read ? (cnt_in_range_q ? cnt_cur : '0) : 32'(best_link);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      route_count <= '0;
      scan_idx    <= '0;
      cmp_valid   <= 1'b0;
      found       <= 1'b0;
      best_len    <= '0;
      best_link   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        route_count <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          scan_idx  <= '0;
          cmp_valid <= 1'b0;
          found     <= 1'b0;
          best_len  <= '0;
          best_link <= '0;
          if (in_acc) begin
            case (opcode)
              OP_CLASSIFY: state <= S_SCAN;
              OP_READ:     state <= S_CREAD;
              default:     state <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          cmp_valid <= (scan_idx != lim);
          if (scan_idx != lim) begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
          if (cmp_valid && better) begin
            found     <= 1'b1;
            best_len  <= route_rd.plen;
            best_link <= route_rd.link;
          end
          // advance once every issued entry has been compared
          if ((scan_idx == lim) && !cmp_valid) begin
            state <= S_CREAD;
          end
        end
        S_CREAD: state <= S_CUPD;
        S_CUPD:  state <= S_OUT;
        S_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_op_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (opcode == OP_CLASSIFY || opcode == OP_READ))
      |=> (state == S_SCAN || state == S_CREAD))
    else $error("classify or read item did not start the sequencer");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (in_acc && opcode == OP_WRITE) |=> (state == S_IDLE))
    else $error("route write left the idle state");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_idx <= lim))
    else $error("scan index ran past the active table length");

  a_cmp_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (state == S_SCAN))
    else $error("compare pending outside the scan");

  a_no_wrap: assert property (@(posedge clk) disable iff (rst)
    cnt_we |-> (cnt_wdata != '0))
    else $error("link counter wrapped");
`endif

endmodule

/* verif/longest_prefix_route_counter_unit_tb.sv */
module longest_prefix_route_counter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lprc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 8;
  localparam int END_CYCLES      = 300;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int PHASES          = 17;
  localparam int PHASE_ITEMS     = 34;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  idx;
    logic [31:0] raddr;
    logic [5:0]  plen;
    logic [2:0]  rlink;
    logic [31:0] paddr;
    logic [2:0]  cidx;
  } req_t;

  typedef struct {
    logic        kind;
    logic [31:0] value;
  } result_t;

  class route_scoreboard;
    logic [31:0] route_addr [MAX_ROUTES_DEF];
    logic [5:0]  route_plen [MAX_ROUTES_DEF];
    logic [2:0]  route_lnk  [MAX_ROUTES_DEF];
    logic [31:0] link_hits  [LINKS_DEF];
    logic [8:0]  route_count;
    result_t     expected_results [$];
    int          errors;

    function new();
      foreach (link_hits[k]) link_hits[k] = '0;
      route_count = '0;
      errors = 0;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Longest matching prefix wins; a strict compare keeps the lowest index on a tie.
    function logic [31:0] predict_link(logic [31:0] addr);
      int         lim;
      int         best_len;
      bit         found;
      logic [2:0] best_link;
      logic [31:0] mask;
      lim = (route_count > MAX_ROUTES_DEF) ? MAX_ROUTES_DEF : int'(route_count);
      best_len = 0;
      found = 1'b0;
      best_link = '0;
      for (int k = 0; k < lim; k++) begin
        mask = (route_plen[k] == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - int'(route_plen[k])));
        if (((addr ^ route_addr[k]) & mask) == 32'h0) begin
          if (!found || int'(route_plen[k]) > best_len) begin
            found = 1'b1;
            best_len = int'(route_plen[k]);
            best_link = route_lnk[k];
          end
        end
      end
      if (best_link < LINKS_DEF && link_hits[best_link] != 32'hFFFF_FFFF)
        link_hits[best_link]++;
      return {29'd0, best_link};
    endfunction

    function void note_input(req_t r);
      result_t e;
      case (r.op)
        OP_WRITE: begin
          if (r.idx < MAX_ROUTES_DEF) begin
            route_addr[r.idx] = r.raddr;
            route_plen[r.idx] = (r.plen > PREFIX_MAX) ? PREFIX_MAX : r.plen;
            route_lnk[r.idx]  = r.rlink;
          end
        end
        OP_CLASSIFY: begin
          e.kind = KIND_LINK;
          e.value = predict_link(r.paddr);
          expected_results.push_back(e);
        end
        OP_READ: begin
          e.kind = KIND_COUNTER;
          e.value = (r.cidx < LINKS_DEF) ? link_hits[r.cidx] : 32'h0;
          expected_results.push_back(e);
        end
        default: ;
      endcase
    endfunction

    task check_result(logic kind, logic [31:0] value);
      result_t e;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d value %h", kind, value));
        return;
      end
      e = expected_results.pop_front();
      if (kind !== e.kind)
        report($sformatf("result_kind %0d, expected %0d", kind, e.kind));
      if (value !== e.value)
        report($sformatf("result_value %h, expected %h", value, e.value));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [8:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = '0;
  logic [7:0]  entry_index = '0;
  logic [31:0] route_address = '0;
  logic [5:0]  prefix_length = '0;
  logic [2:0]  route_link = '0;
  logic [31:0] packet_address = '0;
  logic [2:0]  counter_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        result_kind;
  logic [31:0] result_value;

  route_scoreboard sb = new();
  logic [31:0] addr_pool [4];
  bit          hold_request = 1'b0;
  bit          rx_quiet = 1'b0;
  bit          tx_quiet = 1'b0;
  int          idle_cycles = 0;

  longest_prefix_route_counter_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .entry_index    (entry_index),
    .route_address  (route_address),
    .prefix_length  (prefix_length),
    .route_link     (route_link),
    .packet_address (packet_address),
    .counter_index  (counter_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_kind    (result_kind),
    .result_value   (result_value)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function logic [31:0] near_pool();
    return addr_pool[$urandom_range(0, 3)] ^ ($urandom() >> $urandom_range(0, 32));
  endfunction

  function logic [5:0] pick_plen();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 6'($urandom_range(33, 63));
    if (r < 50) return 6'(8 * $urandom_range(0, 4));
    return 6'($urandom_range(0, 32));
  endfunction

  function logic [2:0] pick_link();
    return ($urandom_range(0, 99) < 8) ? 3'd0 : 3'($urandom_range(1, 7));
  endfunction

  // Unused fields carry random content.
  function req_t noise_req();
    req_t r;
    r.op = 2'($urandom());
    r.idx = 8'($urandom());
    r.raddr = $urandom();
    r.plen = 6'($urandom());
    r.rlink = 3'($urandom());
    r.paddr = $urandom();
    r.cidx = 3'($urandom());
    return r;
  endfunction

  function req_t write_req(logic [7:0] idx, logic [31:0] a, logic [5:0] pl, logic [2:0] lk);
    req_t r;
    r = noise_req();
    r.op = OP_WRITE;
    r.idx = idx;
    r.raddr = a;
    r.plen = pl;
    r.rlink = lk;
    return r;
  endfunction

  function req_t classify_req(logic [31:0] a);
    req_t r;
    r = noise_req();
    r.op = OP_CLASSIFY;
    r.paddr = a;
    return r;
  endfunction

  function req_t read_req(logic [2:0] c);
    req_t r;
    r = noise_req();
    r.op = OP_READ;
    r.cidx = c;
    return r;
  endfunction

  function req_t random_request(int active);
    req_t r;
    int   sel;
    logic [7:0] idx;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      // keep most writes inside the entries that take part in matching
      if (active > 0 && $urandom_range(0, 99) < 60) idx = 8'($urandom_range(0, active - 1));
      else idx = 8'($urandom());
      r = write_req(idx, near_pool(), pick_plen(), pick_link());
    end else if (sel < 80) begin
      r = classify_req(($urandom_range(0, 99) < 80) ? near_pool() : $urandom());
    end else if (sel < 95) begin
      r = read_req(3'($urandom()));
    end else begin
      r = noise_req();
      r.op = OP_UNUSED;
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task offer(req_t r);
    in_valid <= 1'b1;
    opcode <= r.op;
    entry_index <= r.idx;
    route_address <= r.raddr;
    prefix_length <= r.plen;
    route_link <= r.rlink;
    packet_address <= r.paddr;
    counter_index <= r.cidx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task idle(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task set_route_count(logic [8:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.route_count = v;
  endtask

  task run_list(req_t q[$]);
    foreach (q[k]) begin
      offer(q[k]);
      idle(pick_gap());
    end
  endtask

  // Receiver: random stall stretches, plus one long hold on request.
  initial begin : receiver
    int left;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0 && hold_request) begin
        left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (left == 0 && !rx_quiet) left = pick_gap();
      if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    bit   moved;
    req_t seen;
    if (!rst) begin
      moved = 1'b0;
      // check before noting: a result never stems from the item taken at the same edge
      if (out_valid && !out_stall) begin
        sb.check_result(result_kind, result_value);
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        seen.op = opcode;
        seen.idx = entry_index;
        seen.raddr = route_address;
        seen.plen = prefix_length;
        seen.rlink = route_link;
        seen.paddr = packet_address;
        seen.cidx = counter_index;
        sb.note_input(seen);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    req_t plan [$];
    int   count;
    int   active;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (addr_pool[k]) addr_pool[k] = $urandom();

    // Empty table: classifies find no route and return link 0.
    plan.push_back(read_req(3'd0));
    plan.push_back(classify_req(32'hFFFF_FFFF));
    plan.push_back(classify_req(32'h0000_0000));
    plan.push_back(noise_req());
    plan[3].op = OP_UNUSED;
    plan.push_back(read_req(3'd0));
    plan.push_back(read_req(3'd7));
    // zero-prefix default, overlapping prefixes, a tie, an over-long prefix, link 0
    plan.push_back(write_req(8'd0, 32'h1234_5678, 6'd0, 3'd1));
    plan.push_back(write_req(8'd1, 32'hC0A8_0100, 6'd24, 3'd2));
    plan.push_back(write_req(8'd2, 32'hC0A8_0105, 6'd63, 3'd3));
    plan.push_back(write_req(8'd3, 32'hC0A8_0000, 6'd16, 3'd4));
    plan.push_back(write_req(8'd4, 32'hC0A8_01FF, 6'd24, 3'd5));
    plan.push_back(write_req(8'd5, 32'hFFFF_FFFF, 6'd32, 3'd7));
    plan.push_back(write_req(8'd6, 32'h0000_0000, 6'd1, 3'd6));
    plan.push_back(write_req(8'd7, 32'h8000_0000, 6'd1, 3'd0));
    run_list(plan);
    wait_drained();
    set_route_count(9'd8);

    plan.delete();
    plan.push_back(classify_req(32'hC0A8_0105));
    plan.push_back(classify_req(32'hC0A8_0199));
    plan.push_back(classify_req(32'hC0A8_FF00));
    plan.push_back(classify_req(32'h0A00_0001));
    plan.push_back(classify_req(32'hFFFF_FFFF));
    plan.push_back(classify_req(32'h8000_0001));
    plan.push_back(read_req(3'd2));
    plan.push_back(read_req(3'd0));
    plan.push_back(read_req(3'd7));
    run_list(plan);

    // Fill the whole table so that any route count reads written entries only.
    for (int k = 0; k < MAX_ROUTES_DEF; k++) begin
      offer(write_req(8'(k), near_pool(), pick_plen(), pick_link()));
      idle(pick_gap());
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       count = 256;
        1:       count = 511;
        2:       count = 0;
        3:       count = 1;
        8:       count = 255;
        12:      count = 300;
        default: count = $urandom_range(2, 24);
      endcase
      active = (count > MAX_ROUTES_DEF) ? MAX_ROUTES_DEF : count;
      wait_drained();
      set_route_count(9'(count));
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      // receiver holds off while the sender keeps offering
      if (p == 0) hold_request = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        offer(random_request(active));
        if (i == PHASE_ITEMS / 2 && (p == 4 || $urandom_range(0, 3) == 0))
          wait_drained();
        else if (!tx_quiet)
          idle(pick_gap());
      end
    end

    wait_drained();
    rx_quiet = 1'b0;
    repeat (END_CYCLES) @(negedge clk);
    if (sb.expected_results.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_results.size()));
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
